// ===== sv/mmlp_pkg.sv =====
// Shared types and constants for the memory-map line parser.
// Holds the parse phases, status codes, character codes and the record type.
// No dependencies; the other files that use it refer to it by scoped names.
package mmlp_pkg;

    localparam int NameCapacity = 1024;
    localparam int CountW       = $clog2(NameCapacity + 1);
    localparam int NameLenW     = 10;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_P      = 8'h70;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_S      = 8'h73;
    localparam logic [7:0] CH_W      = 8'h77;
    localparam logic [7:0] CH_X      = 8'h78;

    typedef enum logic [3:0] {
        PH_START, PH_END, PH_FR, PH_FW, PH_FX, PH_FS, PH_SP,
        PH_OFF, PH_MAJ, PH_MIN, PH_INODE, PH_GAP, PH_NAME
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK   = 3'd0,
        ST_SEP  = 3'd1,
        ST_FLAG = 3'd2,
        ST_NULL = 3'd3,
        ST_DESC = 3'd4,
        ST_OVF  = 3'd5
    } t_status;

    typedef struct packed {
        logic [63:0]         start_addr;
        logic [63:0]         end_addr;
        logic [63:0]         region_size;
        logic [2:0]          prot;
        logic                shared;
        logic                anonymous;
        logic [63:0]         file_offset;
        logic [31:0]         dev_major;
        logic [31:0]         dev_minor;
        logic [63:0]         inode;
        logic [NameLenW-1:0] name_length;
        logic [2:0]          status;
    } t_record;

endpackage

// ===== sv/mmlp_ifs.sv =====
// Valid/ready channel interfaces of the memory-map line parser.
// The byte channel carries one text byte, the record channel one line record.
// Depends on mmlp_pkg for the record type.
interface mmlp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;

    modport source(output valid, output char_byte, input ready);
    modport sink(input valid, input char_byte, output ready);
endinterface

interface mmlp_rec_if;
    logic             valid;
    logic             ready;
    mmlp_pkg::t_record rec;

    modport source(output valid, output rec, input ready);
    modport sink(input valid, input rec, output ready);
endinterface

// ===== sv/mmlp_in_stage.sv =====
// Input register of the memory-map line parser.
// Captures one byte transaction and holds it until the parse stage takes it.
// Depends on mmlp_ifs.
module mmlp_in_stage (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mmlp_byte_if.sink    i_in,
    input  logic         i_take,
    output logic         o_valid,
    output logic [7:0]   o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign i_in.ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_byte     = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.char_byte;
        end
    end

endmodule

// ===== sv/mmlp_parse.sv =====
// Parse stage of the memory-map line parser: line state and per-byte update.
// Builds the line record when a newline is taken.
// Depends on mmlp_pkg.
module mmlp_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    input  logic              i_out_free,
    output logic              o_take,
    output logic              o_emit,
    output mmlp_pkg::t_record o_rec
);

    mmlp_pkg::t_phase  r_phase, n_phase;
    mmlp_pkg::t_status r_err, n_err;
    logic [63:0] r_acc, n_acc;
    logic        r_digit, n_digit;
    logic [63:0] r_start, n_start;
    logic [63:0] r_end, n_end;
    logic [63:0] r_size, n_size;
    logic [63:0] r_offset, n_offset;
    logic [31:0] r_major, n_major;
    logic [31:0] r_minor, n_minor;
    logic [3:0]  r_flags, n_flags;
    logic [mmlp_pkg::CountW-1:0] r_count, n_count;
    logic        r_bracket, n_bracket;

    logic        is_newline;
    logic        skip;
    logic        is_hex;
    logic [3:0]  hex_d;
    logic        is_dec;
    logic [63:0] acc_hex;
    logic [63:0] acc_dec;
    logic        acc_zero;
    logic [64:0] range_diff;
    logic        gap;
    logic [mmlp_pkg::CountW-1:0] count_inc;

    assign is_newline = (i_byte == mmlp_pkg::CH_LF);
    assign o_take     = i_valid && (!is_newline || i_out_free);
    assign o_emit     = o_take && is_newline;

    // A zero byte before anything else on a line is dropped.
    assign skip = (r_phase == mmlp_pkg::PH_START) && !r_digit
               && (r_err == mmlp_pkg::ST_OK) && (i_byte == mmlp_pkg::CH_NUL);

    always_comb begin
        is_hex = 1'b1;
        hex_d  = 4'd0;
        if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
            hex_d = 4'(i_byte - 8'h30);
        end else if (i_byte >= 8'h61 && i_byte <= 8'h66) begin
            hex_d = 4'(i_byte - 8'h57);
        end else if (i_byte >= 8'h41 && i_byte <= 8'h46) begin
            hex_d = 4'(i_byte - 8'h37);
        end else begin
            is_hex = 1'b0;
        end
    end

    assign is_dec     = (i_byte >= 8'h30) && (i_byte <= 8'h39);
    assign acc_hex    = {r_acc[59:0], hex_d};
    assign acc_dec    = {r_acc[60:0], 3'b000} + {r_acc[62:0], 1'b0} + {60'd0, hex_d};
    assign acc_zero   = (r_acc == 64'd0);
    assign range_diff = {1'b0, r_acc} - {1'b0, r_start};
    assign count_inc  = r_count + 1'b1;

    always_comb begin
        n_phase   = r_phase;
        n_err     = r_err;
        n_acc     = r_acc;
        n_digit   = r_digit;
        n_start   = r_start;
        n_end     = r_end;
        n_size    = r_size;
        n_offset  = r_offset;
        n_major   = r_major;
        n_minor   = r_minor;
        n_flags   = r_flags;
        n_count   = r_count;
        n_bracket = r_bracket;
        gap       = 1'b0;
        if (!skip && r_err == mmlp_pkg::ST_OK) begin
            unique case (r_phase)
                mmlp_pkg::PH_START: begin
                    if (is_hex) begin
                        n_acc   = acc_hex;
                        n_digit = 1'b1;
                    end else if (acc_zero) begin
                        n_err = mmlp_pkg::ST_NULL;
                    end else if (i_byte != mmlp_pkg::CH_DASH) begin
                        n_err = mmlp_pkg::ST_SEP;
                    end else begin
                        n_start = r_acc;
                        n_acc   = '0;
                        n_phase = mmlp_pkg::PH_END;
                    end
                end
                mmlp_pkg::PH_END: begin
                    if (is_hex) begin
                        n_acc = acc_hex;
                    end else if (acc_zero) begin
                        n_err = mmlp_pkg::ST_NULL;
                    end else if (i_byte != mmlp_pkg::CH_SPACE) begin
                        n_err = mmlp_pkg::ST_SEP;
                    end else if (range_diff[64]) begin
                        n_err = mmlp_pkg::ST_DESC;
                    end else begin
                        n_end   = r_acc;
                        n_size  = range_diff[63:0];
                        n_acc   = '0;
                        n_phase = mmlp_pkg::PH_FR;
                    end
                end
                mmlp_pkg::PH_FR: begin
                    if (i_byte == mmlp_pkg::CH_R) begin
                        n_flags[0] = 1'b1;
                    end else if (i_byte != mmlp_pkg::CH_DASH) begin
                        n_err = mmlp_pkg::ST_FLAG;
                    end
                    n_phase = mmlp_pkg::PH_FW;
                end
                mmlp_pkg::PH_FW: begin
                    if (i_byte == mmlp_pkg::CH_W) begin
                        n_flags[1] = 1'b1;
                    end else if (i_byte != mmlp_pkg::CH_DASH) begin
                        n_err = mmlp_pkg::ST_FLAG;
                    end
                    n_phase = mmlp_pkg::PH_FX;
                end
                mmlp_pkg::PH_FX: begin
                    if (i_byte == mmlp_pkg::CH_X) begin
                        n_flags[2] = 1'b1;
                    end else if (i_byte != mmlp_pkg::CH_DASH) begin
                        n_err = mmlp_pkg::ST_FLAG;
                    end
                    n_phase = mmlp_pkg::PH_FS;
                end
                mmlp_pkg::PH_FS: begin
                    if (i_byte == mmlp_pkg::CH_S) begin
                        n_flags[3] = 1'b1;
                    end else if (i_byte != mmlp_pkg::CH_P) begin
                        n_err = mmlp_pkg::ST_FLAG;
                    end
                    n_phase = mmlp_pkg::PH_SP;
                end
                mmlp_pkg::PH_SP: begin
                    if (i_byte == mmlp_pkg::CH_SPACE) begin
                        n_phase = mmlp_pkg::PH_OFF;
                    end else begin
                        n_err = mmlp_pkg::ST_SEP;
                    end
                end
                mmlp_pkg::PH_OFF: begin
                    if (is_hex) begin
                        n_acc = acc_hex;
                    end else if (i_byte == mmlp_pkg::CH_SPACE) begin
                        n_offset = r_acc;
                        n_acc    = '0;
                        n_phase  = mmlp_pkg::PH_MAJ;
                    end else begin
                        n_err = mmlp_pkg::ST_SEP;
                    end
                end
                mmlp_pkg::PH_MAJ, mmlp_pkg::PH_MIN: begin
                    // A device number may not grow past 32 bits.
                    if (is_hex) begin
                        if (|r_acc[63:28]) begin
                            n_err = mmlp_pkg::ST_OVF;
                        end else begin
                            n_acc = acc_hex;
                        end
                    end else if (r_phase == mmlp_pkg::PH_MAJ
                                 && i_byte == mmlp_pkg::CH_COLON) begin
                        n_major = r_acc[31:0];
                        n_acc   = '0;
                        n_phase = mmlp_pkg::PH_MIN;
                    end else if (r_phase == mmlp_pkg::PH_MIN
                                 && i_byte == mmlp_pkg::CH_SPACE) begin
                        n_minor = r_acc[31:0];
                        n_acc   = '0;
                        n_phase = mmlp_pkg::PH_INODE;
                    end else begin
                        n_err = mmlp_pkg::ST_SEP;
                    end
                end
                mmlp_pkg::PH_INODE: begin
                    if (is_dec) begin
                        n_acc = acc_dec;
                    end else begin
                        gap = 1'b1;
                    end
                end
                mmlp_pkg::PH_GAP: begin
                    gap = 1'b1;
                end
                mmlp_pkg::PH_NAME: begin
                    if (!is_newline) begin
                        n_count = count_inc;
                        if (count_inc >= mmlp_pkg::CountW'(mmlp_pkg::NameCapacity)) begin
                            n_err = mmlp_pkg::ST_OVF;
                        end
                    end
                end
                default: begin
                    n_err = mmlp_pkg::ST_SEP;
                end
            endcase

            // Between the inode and the name: spaces, then a name opener.
            if (gap) begin
                if (i_byte == mmlp_pkg::CH_SPACE) begin
                    n_phase = mmlp_pkg::PH_GAP;
                end else if (i_byte == mmlp_pkg::CH_SLASH || i_byte == mmlp_pkg::CH_LBRACK
                             || i_byte == mmlp_pkg::CH_LPAREN) begin
                    n_count   = mmlp_pkg::CountW'(1);
                    n_bracket = (i_byte == mmlp_pkg::CH_LBRACK);
                    n_phase   = mmlp_pkg::PH_NAME;
                    if (mmlp_pkg::NameCapacity <= 1) begin
                        n_err = mmlp_pkg::ST_OVF;
                    end
                end else if (!is_newline) begin
                    n_err = mmlp_pkg::ST_SEP;
                end
            end
        end
    end

    // The record reads the held state; a newline never changes the fields of a good line.
    always_comb begin
        o_rec        = '0;
        o_rec.status = n_err;
        if (n_err == mmlp_pkg::ST_OK) begin
            o_rec.start_addr  = r_start;
            o_rec.end_addr    = r_end;
            o_rec.region_size = r_size;
            o_rec.prot        = r_flags[2:0];
            o_rec.shared      = r_flags[3];
            o_rec.anonymous   = (r_count == '0) || r_bracket;
            o_rec.file_offset = r_offset;
            o_rec.dev_major   = r_major;
            o_rec.dev_minor   = r_minor;
            o_rec.inode       = r_acc;
            o_rec.name_length = mmlp_pkg::NameLenW'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_emit) begin
            r_phase   <= mmlp_pkg::PH_START;
            r_err     <= mmlp_pkg::ST_OK;
            r_acc     <= '0;
            r_digit   <= 1'b0;
            r_start   <= '0;
            r_end     <= '0;
            r_size    <= '0;
            r_offset  <= '0;
            r_major   <= '0;
            r_minor   <= '0;
            r_flags   <= '0;
            r_count   <= '0;
            r_bracket <= 1'b0;
        end else if (o_take) begin
            r_phase   <= n_phase;
            r_err     <= n_err;
            r_acc     <= n_acc;
            r_digit   <= n_digit;
            r_start   <= n_start;
            r_end     <= n_end;
            r_size    <= n_size;
            r_offset  <= n_offset;
            r_major   <= n_major;
            r_minor   <= n_minor;
            r_flags   <= n_flags;
            r_count   <= n_count;
            r_bracket <= n_bracket;
        end
    end

endmodule

// ===== sv/mmlp_out_stage.sv =====
// Result register of the memory-map line parser.
// Holds one line record until the record transaction completes.
// Depends on mmlp_pkg and mmlp_ifs.
module mmlp_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  mmlp_pkg::t_record i_rec,
    output logic              o_free,
    mmlp_rec_if.source        o_out
);

    logic              r_valid;
    mmlp_pkg::t_record r_rec;

    assign o_free      = !r_valid || o_out.ready;
    assign o_out.valid = r_valid;
    assign o_out.rec   = r_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rec <= i_rec;
        end
    end

endmodule

// ===== sv/memory_map_line_parser.sv =====
// Top level of the memory-map line parser: input register, parse stage, result register.
// Depends on mmlp_pkg, mmlp_ifs, mmlp_in_stage, mmlp_parse and mmlp_out_stage.
//
//   Channel  Dir  Payload             Transaction
//   i_in     in   char_byte [7:0]     one byte of map text
//   o_out    out  rec (t_record)      one record per newline
//
// One byte is taken every cycle while no newline stalls. A newline taken from the input register
// is parsed combinationally and its record is loaded into the result register, where it can
// be taken (input register, combinational parse, result register).
// Reset is synchronous on i_rst_n and returns the parser to the start of a line.
// Only a newline can stall, and only while the result register holds a record
// that has not been taken; the input is held off until that record moves on.
module memory_map_line_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mmlp_byte_if.sink  i_in,
    mmlp_rec_if.source o_out
);

    logic              byte_valid;
    logic [7:0]        byte_data;
    logic              take;
    logic              emit;
    logic              out_free;
    mmlp_pkg::t_record rec;

    mmlp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_valid (byte_valid),
        .o_byte  (byte_data)
    );

    mmlp_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (byte_valid),
        .i_byte     (byte_data),
        .i_out_free (out_free),
        .o_take     (take),
        .o_emit     (emit),
        .o_rec      (rec)
    );

    mmlp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (emit),
        .i_rec   (rec),
        .o_free  (out_free),
        .o_out   (o_out)
    );

    // A held byte that the parse stage has not taken stays in the input register.
    a_hold_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        byte_valid && !take |=> byte_valid && $stable(byte_data))
        else $error("untaken byte lost from input register");

    // Records are produced only for a newline and only into a free result register.
    a_emit_newline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> byte_data == mmlp_pkg::CH_LF && out_free)
        else $error("record emitted without newline or into a full register");

    // An error record carries nothing but its status.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.rec.status != mmlp_pkg::ST_OK
        |-> o_out.rec.start_addr == 64'd0 && o_out.rec.inode == 64'd0
            && o_out.rec.name_length == '0)
        else $error("error record has nonzero fields");

    // A good record never describes a descending range.
    a_range_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.rec.status == mmlp_pkg::ST_OK
        |-> o_out.rec.end_addr >= o_out.rec.start_addr
            && o_out.rec.start_addr != 64'd0)
        else $error("good record with bad address range");

endmodule
